>>> src/xcpf_pkg.sv
package xcpf_pkg;

  localparam int XCPF_QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_START_MARKER  = 2'd0;
  localparam logic [1:0] REG_END_MARKER    = 2'd1;
  localparam logic [1:0] REG_SEQUENCE_MODE = 2'd2;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    JOB_STRAY,
    JOB_HEADER,
    JOB_DATA
  } job_kind_t;

  // first: payload length for a header, data byte for a payload job
  typedef struct packed {
    job_kind_t   kind;
    logic        err;
    logic        with_seq;
    logic        fin;
    logic [7:0]  first;
    logic [7:0]  seq;
    logic [7:0]  cmd;
    logic [7:0]  csum;
  } job_t;

endpackage

>>> src/xcpf_queue.sv
module xcpf_queue #(
  parameter int DEPTH = xcpf_pkg::XCPF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xcpf_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output xcpf_pkg::job_t dout,
  output logic           empty
);
  import xcpf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

>>> src/xcpf_front.sv
module xcpf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           op,
  input  logic [7:0]     payload_length,
  input  logic [7:0]     command,
  input  logic [7:0]     data_byte,
  input  logic           sequence_mode,
  input  logic           q_full,
  output logic           q_push,
  output xcpf_pkg::job_t q_din
);
  import xcpf_pkg::*;

  logic [7:0] sequence_counter;
  logic [7:0] running_checksum;
  logic [7:0] bytes_remaining;
  logic       packet_open;

  logic       accept;
  logic [7:0] seq_term;
  logic [7:0] csum_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign seq_term = sequence_mode ? sequence_counter : 8'd0;

  always_comb begin
    csum_next      = running_checksum;
    q_din          = '0;
    q_din.seq      = sequence_counter;
    q_din.cmd      = command;
    q_din.with_seq = sequence_mode;
    if (op == OP_PAYLOAD) begin
      if (!packet_open) begin
        q_din.kind = JOB_STRAY;
        q_din.err  = 1'b1;
      end else begin
        csum_next   = running_checksum ^ data_byte;
        q_din.kind  = JOB_DATA;
        q_din.first = data_byte;
        q_din.fin   = (bytes_remaining == 8'd1);
      end
    end else begin
      csum_next   = payload_length ^ seq_term ^ command;
      q_din.kind  = JOB_HEADER;
      q_din.err   = packet_open;
      q_din.first = payload_length;
      q_din.fin   = (payload_length == 8'd0);
    end
    q_din.csum = csum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      running_checksum <= '0;
      bytes_remaining  <= '0;
      packet_open      <= 1'b0;
    end else if (accept) begin
      if (op == OP_PAYLOAD) begin
        if (packet_open) begin
          running_checksum <= csum_next;
          bytes_remaining  <= bytes_remaining - 1'b1;
          packet_open      <= (bytes_remaining != 8'd1);
        end
      end else begin
        running_checksum <= csum_next;
        bytes_remaining  <= payload_length;
        packet_open      <= (payload_length != 8'd0);
        if (sequence_mode) begin
          sequence_counter <= sequence_counter + 1'b1;
        end
      end
    end
  end

  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_PAYLOAD && packet_open && bytes_remaining == 8'd1) |=> !packet_open)
    else $error("packet still open after its last payload byte");

endmodule

>>> src/xcpf_back.sv
module xcpf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  xcpf_pkg::job_t q_dout,
  output logic           q_pop,
  input  logic [7:0]     start_marker,
  input  logic [7:0]     end_marker,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic           m_axis_tlast,
  output logic           m_axis_tuser
);
  import xcpf_pkg::*;

  typedef enum logic [2:0] {
    SL_START,
    SL_LEN,
    SL_SEQ,
    SL_CMD,
    SL_DATA,
    SL_CSUM,
    SL_END,
    SL_STRAY
  } slot_t;

  slot_t      slot;
  slot_t      cur;
  slot_t      slot_next;
  logic       busy;
  logic       emit;
  logic       done;
  logic [7:0] byte_out;

  assign emit  = !q_empty && (!m_axis_tvalid || m_axis_tready);
  assign q_pop = emit && done;

  always_comb begin
    if (busy) begin
      cur = slot;
    end else begin
      case (q_dout.kind)
        JOB_HEADER: cur = SL_START;
        JOB_DATA:   cur = SL_DATA;
        default:    cur = SL_STRAY;
      endcase
    end
  end

  always_comb begin
    byte_out  = 8'd0;
    slot_next = SL_START;
    done      = 1'b0;
    case (cur)
      SL_START: begin
        byte_out  = start_marker;
        slot_next = SL_LEN;
      end
      SL_LEN: begin
        byte_out  = q_dout.first;
        slot_next = q_dout.with_seq ? SL_SEQ : SL_CMD;
      end
      SL_SEQ: begin
        byte_out  = q_dout.seq;
        slot_next = SL_CMD;
      end
      SL_CMD: begin
        byte_out  = q_dout.cmd;
        slot_next = SL_CSUM;
        done      = !q_dout.fin;
      end
      SL_DATA: begin
        byte_out  = q_dout.first;
        slot_next = SL_CSUM;
        done      = !q_dout.fin;
      end
      SL_CSUM: begin
        byte_out  = q_dout.csum;
        slot_next = SL_END;
      end
      SL_END: begin
        byte_out = end_marker;
        done     = 1'b1;
      end
      default: begin
        byte_out = 8'd0;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      busy          <= 1'b0;
      slot          <= SL_START;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= byte_out;
        m_axis_tlast  <= done;
        m_axis_tuser  <= q_dout.err;
        busy          <= !done;
        slot          <= slot_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_stray_flagged: assert property (@(posedge clk) disable iff (rst)
    (emit && cur == SL_STRAY) |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser))
    else $error("stray payload byte not flagged as a single error transaction");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (emit && cur == SL_END) |-> q_pop)
    else $error("end marker without releasing its job");

endmodule

>>> src/xor_checksum_packet_framer_unit.sv
// Byte packet framer with XOR checksum. A header transaction (tuser 0) emits start marker,
// length, sequence byte (sequence mode only) and command, then checksum and end marker if
// the length is zero; a payload transaction (tuser 1) emits its byte, then checksum and end
// marker on the final byte; a payload byte with no packet open emits one zero byte flagged
// as error. The output stream carries one byte per cycle while tready is high and a job is
// queued; a payload item produces 1 to 3 bytes and a header 3 to 6. Inputs are taken one
// per cycle while the job queue (QUEUE_DEPTH entries) between the input classifier and the
// byte sequencer has room; tready drops when it fills.
module xor_checksum_packet_framer_unit #(
  parameter int QUEUE_DEPTH = xcpf_pkg::XCPF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // payload_length[7:0], command[15:8], data_byte[23:16]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import xcpf_pkg::*;

  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic       sequence_mode;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  job_t       q_din;
  job_t       q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= 8'd170;
      end_marker    <= 8'd85;
      sequence_mode <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_MARKER:  start_marker  <= cfg_data;
        REG_END_MARKER:    end_marker    <= cfg_data;
        REG_SEQUENCE_MODE: sequence_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  xcpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .op             (s_axis_tuser),
    .payload_length (s_axis_tdata[7:0]),
    .command        (s_axis_tdata[15:8]),
    .data_byte      (s_axis_tdata[23:16]),
    .sequence_mode  (sequence_mode),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_din          (q_din)
  );

  xcpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  xcpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_dout        (q_dout),
    .q_pop         (q_pop),
    .start_marker  (start_marker),
    .end_marker    (end_marker),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
